FILE: design/erd_pkg.sv
package erd_pkg;

    // Ring and tap geometry
    localparam int DELAY_DEPTH   = 4096;
    localparam int ADDR_W        = $clog2(DELAY_DEPTH);
    localparam int NUM_TAPS      = 8;
    localparam int TAP_W         = $clog2(NUM_TAPS);
    localparam int DLY_FIELD_W   = 16;
    localparam int DLY_WORD_W    = 64;

    // Sample and gain formats
    localparam int SAMPLE_W      = 24;
    localparam int GAIN_W        = 17;
    localparam logic [GAIN_W-1:0] Q16_ONE = GAIN_W'(65536);

    // Datapath widths
    localparam int PROD_W        = SAMPLE_W + GAIN_W + 1;   // sample x signed gain
    localparam int TAPSUM_W      = 43;                      // sum of eight weighted taps
    localparam int TS_LO_W       = 22;
    localparam int TS_HI_W       = TAPSUM_W - TS_LO_W;
    localparam int MHI_W         = TS_HI_W + GAIN_W + 1;
    localparam int MLO_W         = TS_LO_W + GAIN_W;
    localparam int ACC_W         = 62;
    localparam int LP_SUM_W      = PROD_W + 1;
    localparam int SAT_W         = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W     = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LP_COEFF  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_EARLY     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DLY_LOW   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DLY_HIGH  = CFG_IDX_W'(4);

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(2 ** (SAMPLE_W - 1));

    // Control from the sequencer to the mixing datapath
    typedef struct packed {
        logic             clear;
        logic             prod_en;
        logic             acc_en;
        logic [TAP_W-1:0] gain_idx;
        logic             mul_en;
        logic             sum_en;
        logic             round_en;
    } t_mix_ctrl;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // Fixed tap weights, Q1.16: 1.0 down to 0.3
    function automatic logic [GAIN_W-1:0] tap_gain(input logic [TAP_W-1:0] k);
        logic [GAIN_W-1:0] g;
        case (k)
            3'd0:    g = GAIN_W'(65536);
            3'd1:    g = GAIN_W'(58982);
            3'd2:    g = GAIN_W'(52429);
            3'd3:    g = GAIN_W'(45875);
            3'd4:    g = GAIN_W'(39322);
            3'd5:    g = GAIN_W'(32768);
            3'd6:    g = GAIN_W'(26214);
            3'd7:    g = GAIN_W'(19661);
            default: g = GAIN_W'(0);
        endcase
        return g;
    endfunction

endpackage

FILE: design/early_reflection_multitap_delay.sv
// Early-reflection multitap delay. Each input item is one signed Q1.23 sample;
// each produces exactly one output item, in order. The sample passes a one-pole
// lowpass (coefficient lowpass_coeff) and is stored in a 4096-entry ring; eight
// taps read the ring at the delays in tap_delays_low/high (clamped to 1..4095,
// a delay of d giving the filtered sample from d items earlier, zero before
// that many items have gone in), weighted by fixed gains 1.0 down to 0.3. The
// output is sample*dry_gain + tap sum*early_gain, rounded half up and saturated
// to 24 bits. Gain writes keep their low 17 bits, and a value above 1.0 is
// clamped to 1.0; indexes above 4 are ignored. Config writes are always taken
// (ready tied high) but must only be issued while idle.
// Rate: one item at a time; the input stalls through the 13 datapath steps
// until the output load. This is set by the eight tap reads going one per
// cycle through the single read port of the ring, followed by the multiply
// pipe and the split tap-sum x early-gain multiply. A finished result waits
// in the output register while the next item is accepted; if it is still
// stalled when the next result is ready, the block holds until it is taken.
// The ring needs no clearing pass after reset: the write pointer and a wrapped
// flag tell which entries have been written, so reads of unwritten entries
// return zero.
module early_reflection_multitap_delay
    import erd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input item channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    // output item channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    // config write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DLY_WORD_W-1:0]       i_cfg_data
);

    // Sequencer step numbers
    localparam int CNT_W         = $clog2(NUM_TAPS + 5);
    localparam int STEP_LP_MUL   = 0;
    localparam int STEP_LP_UPD   = 1;
    localparam int STEP_WRITE    = NUM_TAPS;
    localparam int STEP_MIX_MUL  = NUM_TAPS + 2;
    localparam int STEP_MIX_SUM  = NUM_TAPS + 3;
    localparam int STEP_MIX_RND  = NUM_TAPS + 4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [GAIN_W-1:0]          r_lp_coeff;
    logic [GAIN_W-1:0]          r_dry;
    logic [GAIN_W-1:0]          r_early;
    logic [DLY_WORD_W-1:0]      r_dly_low;
    logic [DLY_WORD_W-1:0]      r_dly_high;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic                       w_in_acc;
    logic                       w_out_load;
    logic                       w_run;
    logic [CNT_W-1:0]           w_cnt_m1;
    logic [TAP_W-1:0]           w_tap;
    logic [DLY_WORD_W-1:0]      w_dly_word;
    logic [DLY_FIELD_W-1:0]     w_dly_raw;
    logic [ADDR_W-1:0]          w_dly;
    logic [ADDR_W:0]            w_diff;
    logic [ADDR_W-1:0]          w_rd_addr;
    logic [ADDR_W-1:0]          w_wp;
    logic                       w_wr_en;
    logic signed [SAMPLE_W-1:0] w_tap_data;
    logic signed [SAMPLE_W-1:0] w_filt;
    logic signed [SAMPLE_W-1:0] w_result;
    t_mix_ctrl                  w_mix;

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [DLY_WORD_W-1:0] v);
        logic [GAIN_W-1:0] g;
        g = v[GAIN_W-1:0];
        if (g > Q16_ONE) begin
            g = Q16_ONE;
        end
        return g;
    endfunction

    assign o_cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_coeff <= GAIN_W'(32768);
            r_dry      <= GAIN_W'(6554);
            r_early    <= GAIN_W'(32768);
            r_dly_low  <= 64'd256427367441171133;
            r_dly_high <= 64'd335804470532965335;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LP_COEFF: r_lp_coeff <= clamp_gain(i_cfg_data);
                REG_DRY_GAIN: r_dry      <= clamp_gain(i_cfg_data);
                REG_EARLY:    r_early    <= clamp_gain(i_cfg_data);
                REG_DLY_LOW:  r_dly_low  <= i_cfg_data;
                REG_DLY_HIGH: r_dly_high <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_load  = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_out;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_W'(STEP_MIX_RND)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= i_sample_in;
        end
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    // Tap address: steps 0..7 issue the read for tap r_cnt
    assign w_run      = (r_state == ST_RUN);
    assign w_tap      = r_cnt[TAP_W-1:0];
    assign w_dly_word = w_tap[TAP_W-1] ? r_dly_high : r_dly_low;
    assign w_dly_raw  = w_dly_word[w_tap[TAP_W-2:0] * DLY_FIELD_W +: DLY_FIELD_W];

    always_comb begin
        if (w_dly_raw == '0) begin
            w_dly = ADDR_W'(1);
        end else if ({1'b0, w_dly_raw} >= (DLY_FIELD_W + 1)'(DELAY_DEPTH)) begin
            w_dly = ADDR_W'(DELAY_DEPTH - 1);
        end else begin
            w_dly = w_dly_raw[ADDR_W-1:0];
        end
    end

    // ring position wp - d, wrapped into the ring
    assign w_diff    = {1'b0, w_wp} - {1'b0, w_dly};
    assign w_rd_addr = w_diff[ADDR_W] ? ADDR_W'(w_diff + (ADDR_W + 1)'(DELAY_DEPTH))
                                      : w_diff[ADDR_W-1:0];

    // filtered sample goes in only once all eight taps have been read
    assign w_wr_en = w_run && (r_cnt == CNT_W'(STEP_WRITE));

    // Datapath control
    assign w_cnt_m1 = r_cnt - 1'b1;
    always_comb begin
        w_mix.clear    = w_in_acc;
        w_mix.prod_en  = w_run && (r_cnt >= CNT_W'(1)) && (r_cnt <= CNT_W'(NUM_TAPS));
        w_mix.acc_en   = w_run && (r_cnt >= CNT_W'(2)) && (r_cnt <= CNT_W'(NUM_TAPS + 1));
        w_mix.gain_idx = w_cnt_m1[TAP_W-1:0];
        w_mix.mul_en   = w_run && (r_cnt == CNT_W'(STEP_MIX_MUL));
        w_mix.sum_en   = w_run && (r_cnt == CNT_W'(STEP_MIX_SUM));
        w_mix.round_en = w_run && (r_cnt == CNT_W'(STEP_MIX_RND));
    end

    erd_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_data (w_filt),
        .o_rd_data (w_tap_data),
        .o_wp      (w_wp)
    );

    erd_lowpass u_lowpass (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_x      (r_x),
        .i_coeff  (r_lp_coeff),
        .i_mul_en (w_run && (r_cnt == CNT_W'(STEP_LP_MUL))),
        .i_upd_en (w_run && (r_cnt == CNT_W'(STEP_LP_UPD))),
        .o_filt   (w_filt)
    );

    erd_mix u_mix (
        .i_clk      (i_clk),
        .i_ctrl     (w_mix),
        .i_tap_data (w_tap_data),
        .i_x        (r_x),
        .i_dry      (r_dry),
        .i_early    (r_early),
        .o_result   (w_result)
    );

endmodule

FILE: design/erd_ring.sv
module erd_ring
    import erd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    input  logic                       i_wr_en,
    input  logic signed [SAMPLE_W-1:0] i_wr_data,
    output logic signed [SAMPLE_W-1:0] o_rd_data,
    output logic [ADDR_W-1:0]          o_wp
);

    logic signed [SAMPLE_W-1:0] r_mem [DELAY_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_raw;
    logic                       r_rd_ok;
    logic [ADDR_W-1:0]          r_wp;
    logic                       r_wrapped;

    // Writes walk the ring in order, so an entry has been written once the
    // pointer has passed it or the ring has wrapped; unwritten entries read 0.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
        r_rd_raw <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_rd_ok <= r_wrapped || (i_rd_addr < r_wp);
            if (i_wr_en) begin
                if (r_wp == ADDR_W'(DELAY_DEPTH - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_raw : '0;
    assign o_wp      = r_wp;

endmodule

FILE: design/erd_lowpass.sv
module erd_lowpass
    import erd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  logic [GAIN_W-1:0]          i_coeff,
    input  logic                       i_mul_en,
    input  logic                       i_upd_en,
    output logic signed [SAMPLE_W-1:0] o_filt
);

    logic [GAIN_W-1:0]          w_om;
    logic signed [GAIN_W:0]     w_om_s;
    logic signed [GAIN_W:0]     w_c_s;
    logic signed [PROD_W-1:0]   w_pa;
    logic signed [PROD_W-1:0]   w_pb;
    logic signed [LP_SUM_W-1:0] w_sum;
    logic signed [LP_SUM_W-1:0] w_shift;
    logic signed [PROD_W-1:0]   r_pa;
    logic signed [PROD_W-1:0]   r_pb;
    logic signed [SAMPLE_W-1:0] r_state;

    assign w_om   = Q16_ONE - i_coeff;
    assign w_om_s = $signed({1'b0, w_om});
    assign w_c_s  = $signed({1'b0, i_coeff});
    assign w_pa   = i_x * w_om_s;
    assign w_pb   = r_state * w_c_s;

    // round half up, then floor by 2^16
    assign w_sum   = LP_SUM_W'(r_pa) + LP_SUM_W'(r_pb) + LP_SUM_W'(32768);
    assign w_shift = w_sum >>> 16;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_pa <= w_pa;
            r_pb <= w_pb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_upd_en) begin
            r_state <= sat_sample(SAT_W'(w_shift));
        end
    end

    assign o_filt = r_state;

endmodule

FILE: design/erd_mix.sv
module erd_mix
    import erd_pkg::*;
(
    input  logic                       i_clk,
    input  t_mix_ctrl                  i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_tap_data,
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  logic [GAIN_W-1:0]          i_dry,
    input  logic [GAIN_W-1:0]          i_early,
    output logic signed [SAMPLE_W-1:0] o_result
);

    logic signed [GAIN_W:0]     w_gain_s;
    logic signed [GAIN_W:0]     w_early_s;
    logic signed [GAIN_W:0]     w_dry_s;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [TAPSUM_W-1:0] r_tapsum;
    logic signed [MHI_W-1:0]    r_m_hi;
    logic [MLO_W-1:0]           r_m_lo;
    logic signed [PROD_W-1:0]   r_m_dry;
    logic signed [ACC_W-1:0]    r_s1;
    logic signed [PROD_W-1:0]   r_dry_d;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    w_acc_sh;

    assign w_gain_s  = $signed({1'b0, tap_gain(i_ctrl.gain_idx)});
    assign w_early_s = $signed({1'b0, i_early});
    assign w_dry_s   = $signed({1'b0, i_dry});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod_en) begin
            r_prod <= i_tap_data * w_gain_s;
        end
        if (i_ctrl.clear) begin
            r_tapsum <= '0;
        end else if (i_ctrl.acc_en) begin
            r_tapsum <= r_tapsum + TAPSUM_W'(r_prod);
        end
        // tap sum times early gain, split in two halves to keep each multiply narrow
        if (i_ctrl.mul_en) begin
            r_m_hi  <= $signed(r_tapsum[TAPSUM_W-1:TS_LO_W]) * w_early_s;
            r_m_lo  <= r_tapsum[TS_LO_W-1:0] * i_early;
            r_m_dry <= i_x * w_dry_s;
        end
        if (i_ctrl.sum_en) begin
            r_s1    <= (ACC_W'(r_m_hi) <<< TS_LO_W) + ACC_W'($signed({1'b0, r_m_lo}));
            r_dry_d <= r_m_dry;
        end
        if (i_ctrl.round_en) begin
            r_acc <= r_s1 + (ACC_W'(r_dry_d) <<< 16) + (ACC_W'(1) <<< 31);
        end
    end

    assign w_acc_sh = r_acc >>> 32;
    assign o_result = sat_sample(SAT_W'(w_acc_sh));

endmodule

FILE: design/erd_checker.sv
module erd_checker
    import erd_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic signed [SAMPLE_W-1:0]  i_sample_in,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic signed [SAMPLE_W-1:0]  o_sample_out,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [CFG_IDX_W-1:0]        i_cfg_index,
    input logic [DLY_WORD_W-1:0]       i_cfg_data
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pending;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    // items taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output item changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left an item in flight");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input taken again while an item is being worked on");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two items outstanding");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_pending) != 2'd0)
        else $error("output item with no input item behind it");

endmodule

bind early_reflection_multitap_delay erd_checker u_erd_checker (.*);
